@@ design/apf_pkg.sv @@
// Shared types and constants for the articulation point finder.
// Holds command codes, result kinds and the controller/datapath buses.
// No dependencies; compile first.
package apf_pkg;

	localparam int DefMaxVertices = 16;
	localparam int CountWidth     = 5;
	localparam int VertexWidth    = 4;
	localparam int CmdWidth       = 2;
	localparam int MaxPoints      = 15;
	localparam logic [CountWidth-1:0] CountReset = 5'd16;

	typedef enum logic [CmdWidth-1:0] {
		CMD_ADD    = 2'd0,
		CMD_CLEAR  = 2'd1,
		CMD_SEARCH = 2'd2
	} cmd_t;

	localparam logic KIND_POINT = 1'b0;
	localparam logic KIND_END   = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic add_edge;
		logic clear_graph;
		logic search_init;
		logic root_next;
		logic root_start;
		logic scan;
		logic pop;
		logic finish_root;
		logic emit_skip;
		logic emit_point;
		logic emit_end;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic root_done;
		logic root_visited;
		logic top_done;
		logic stack_empty;
		logic emit_done;
		logic cut_hit;
		logic out_free;
	} dp_status_t;

endpackage

@@ design/apf_if.sv @@
// Channel interfaces for the articulation point finder.
// Depends on apf_pkg for field widths.
interface apf_req_if;
	logic                            valid;
	logic                            ready;
	logic [apf_pkg::CmdWidth-1:0]    command;
	logic [apf_pkg::VertexWidth-1:0] vertex_a;
	logic [apf_pkg::VertexWidth-1:0] vertex_b;
	modport source (output valid, command, vertex_a, vertex_b, input ready);
	modport sink (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface apf_rsp_if;
	logic                            valid;
	logic                            ready;
	logic                            kind;
	logic [apf_pkg::VertexWidth-1:0] vertex;
	logic                            last;
	modport source (output valid, kind, vertex, last, input ready);
	modport sink (input valid, kind, vertex, last, output ready);
endinterface

@@ design/apf_ctrl.sv @@
// Sequencer for the articulation point finder: accepts commands and
// steps the datapath through root scan, depth-first walk and reporting.
// Depends on apf_pkg.
module apf_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  logic [apf_pkg::CmdWidth-1:0] in_command,
	output logic                         in_ready,
	input  apf_pkg::dp_status_t          status,
	output apf_pkg::dp_cmd_t             cmd
);
	import apf_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ROOT = 4'b0010,
		ST_WALK = 4'b0100,
		ST_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// Next state and datapath commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					unique case (in_command)
						CMD_ADD:    cmd.add_edge    = 1'b1;
						CMD_CLEAR:  cmd.clear_graph = 1'b1;
						CMD_SEARCH: begin
							cmd.search_init = 1'b1;
							state_d         = ST_ROOT;
						end
						default: ;
					endcase
				end
			end
			ST_ROOT: begin
				priority if (status.root_done) begin
					state_d = ST_EMIT;
				end else if (status.root_visited) begin
					cmd.root_next = 1'b1;
				end else begin
					cmd.root_start = 1'b1;
					state_d        = ST_WALK;
				end
			end
			ST_WALK: begin
				priority if (!status.top_done) begin
					cmd.scan = 1'b1;
				end else if (!status.stack_empty) begin
					cmd.pop = 1'b1;
				end else begin
					cmd.finish_root = 1'b1;
					state_d         = ST_ROOT;
				end
			end
			ST_EMIT: begin
				priority if (status.emit_done) begin
					if (status.out_free) begin
						cmd.emit_end = 1'b1;
						state_d      = ST_IDLE;
					end
				end else if (status.cut_hit) begin
					if (status.out_free) cmd.emit_point = 1'b1;
				end else begin
					cmd.emit_skip = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Hold state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ design/apf_dp.sv @@
// Datapath of the articulation point finder: adjacency matrix, visit
// marks, discovery times, walk stack, cut flags and result register.
// Depends on apf_pkg.
module apf_dp #(
	parameter int MAX_VERTICES = apf_pkg::DefMaxVertices
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [apf_pkg::CountWidth-1:0]  cfg_wdata,
	input  logic [apf_pkg::VertexWidth-1:0] vertex_a,
	input  logic [apf_pkg::VertexWidth-1:0] vertex_b,
	input  apf_pkg::dp_cmd_t                cmd,
	output apf_pkg::dp_status_t             status,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            out_kind,
	output logic [apf_pkg::VertexWidth-1:0] out_vertex,
	output logic                            out_last
);
	import apf_pkg::*;

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam int EW = (CW > CountWidth) ? CW : CountWidth;
	localparam logic [CW-1:0] MaxV = CW'(MAX_VERTICES);

	logic [CountWidth-1:0]   count_q;
	logic [MAX_VERTICES-1:0] adj_q [MAX_VERTICES];
	logic [MAX_VERTICES-1:0] visited_q;
	logic [MAX_VERTICES-1:0] cut_q;
	logic [CW-1:0]           disc_q [MAX_VERTICES];
	logic [VW-1:0]           stk_v_q [MAX_VERTICES];
	logic [CW-1:0]           stk_next_q [MAX_VERTICES];
	logic [CW-1:0]           stk_low_q [MAX_VERTICES];
	logic [CW-1:0]           stk_disc_q [MAX_VERTICES];
	logic [VW-1:0]           cur_v_q, root_q;
	logic [CW-1:0]           cur_next_q, cur_low_q, cur_disc_q;
	logic [CW-1:0]           depth_q, clock_q, root_idx_q, emit_idx_q;
	logic [VertexWidth-1:0]  emit_cnt_q;
	logic [1:0]              children_q;
	logic                    out_valid_q, out_kind_q, out_last_q;
	logic [VertexWidth-1:0]  out_vertex_q;

	logic [EW-1:0] a_ext, b_ext, cnt_ext;
	logic          edge_ok;
	logic [VW-1:0] a_idx, b_idx, nb, r_idx, p_idx;
	logic [CW-1:0] n_eff, clock_inc, depth_dec;
	logic          nb_edge, nb_seen;

	// Clamp the vertex count and check edge endpoints
	always_comb begin
		a_ext     = EW'(vertex_a);
		b_ext     = EW'(vertex_b);
		cnt_ext   = EW'(count_q);
		edge_ok   = (a_ext < EW'(MAX_VERTICES)) && (b_ext < EW'(MAX_VERTICES));
		a_idx     = a_ext[VW-1:0];
		b_idx     = b_ext[VW-1:0];
		n_eff     = (cnt_ext > EW'(MAX_VERTICES)) ? MaxV : cnt_ext[CW-1:0];
		nb        = cur_next_q[VW-1:0];
		r_idx     = root_idx_q[VW-1:0];
		depth_dec = depth_q - CW'(1);
		p_idx     = depth_dec[VW-1:0];
		clock_inc = clock_q + CW'(1);
		nb_edge   = adj_q[cur_v_q][nb];
		nb_seen   = visited_q[nb];
	end

	// Status for the sequencer
	always_comb begin
		status.root_done    = root_idx_q >= n_eff;
		status.root_visited = visited_q[r_idx];
		status.top_done     = cur_next_q >= n_eff;
		status.stack_empty  = depth_q == '0;
		status.emit_done    = (emit_idx_q == MaxV) ||
			(emit_cnt_q == VertexWidth'(MaxPoints));
		status.cut_hit      = cut_q[emit_idx_q[VW-1:0]];
		status.out_free     = !out_valid_q || out_ready;
	end

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= CountReset;
		end else if (cfg_we) begin
			count_q <= cfg_wdata;
		end
	end

	// Adjacency matrix: set both directions, or clear all
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_VERTICES; k++) adj_q[k] <= '0;
		end else if (cmd.clear_graph) begin
			for (int k = 0; k < MAX_VERTICES; k++) adj_q[k] <= '0;
		end else if (cmd.add_edge && edge_ok) begin
			adj_q[a_idx][b_idx] <= 1'b1;
			adj_q[b_idx][a_idx] <= 1'b1;
		end
	end

	// Walk control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visited_q  <= '0;
			cut_q      <= '0;
			depth_q    <= '0;
			clock_q    <= '0;
			root_idx_q <= '0;
			emit_idx_q <= '0;
			emit_cnt_q <= '0;
			children_q <= '0;
		end else begin
			if (cmd.search_init) begin
				visited_q  <= '0;
				cut_q      <= '0;
				depth_q    <= '0;
				clock_q    <= '0;
				root_idx_q <= '0;
				emit_idx_q <= '0;
				emit_cnt_q <= '0;
			end
			if (cmd.root_next) root_idx_q <= root_idx_q + CW'(1);
			if (cmd.root_start) begin
				visited_q[r_idx] <= 1'b1;
				clock_q          <= clock_inc;
				children_q       <= '0;
			end
			if (cmd.scan && nb_edge && !nb_seen) begin
				visited_q[nb] <= 1'b1;
				clock_q       <= clock_inc;
				depth_q       <= depth_q + CW'(1);
				if (cur_v_q == root_q && children_q != 2'd2) children_q <= children_q + 2'd1;
			end
			if (cmd.pop) begin
				depth_q <= depth_dec;
				if (stk_v_q[p_idx] != root_q && cur_low_q >= stk_disc_q[p_idx])
					cut_q[stk_v_q[p_idx]] <= 1'b1;
			end
			if (cmd.finish_root) begin
				if (children_q == 2'd2) cut_q[root_q] <= 1'b1;
				root_idx_q <= root_idx_q + CW'(1);
			end
			if (cmd.emit_skip) emit_idx_q <= emit_idx_q + CW'(1);
			if (cmd.emit_point) begin
				emit_idx_q <= emit_idx_q + CW'(1);
				emit_cnt_q <= emit_cnt_q + VertexWidth'(1);
			end
		end
	end

	// Top frame, discovery times and saved frames
	always_ff @(posedge clk) begin
		if (cmd.root_start) begin
			root_q          <= r_idx;
			cur_v_q         <= r_idx;
			cur_next_q      <= '0;
			cur_low_q       <= clock_inc;
			cur_disc_q      <= clock_inc;
			disc_q[r_idx]   <= clock_inc;
		end
		if (cmd.scan) begin
			if (nb_edge && !nb_seen) begin
				stk_v_q[depth_q[VW-1:0]]    <= cur_v_q;
				stk_next_q[depth_q[VW-1:0]] <= cur_next_q + CW'(1);
				stk_low_q[depth_q[VW-1:0]]  <= cur_low_q;
				stk_disc_q[depth_q[VW-1:0]] <= cur_disc_q;
				disc_q[nb] <= clock_inc;
				cur_v_q    <= nb;
				cur_next_q <= '0;
				cur_low_q  <= clock_inc;
				cur_disc_q <= clock_inc;
			end else begin
				cur_next_q <= cur_next_q + CW'(1);
				if (nb_edge && disc_q[nb] < cur_low_q) cur_low_q <= disc_q[nb];
			end
		end
		if (cmd.pop) begin
			cur_v_q    <= stk_v_q[p_idx];
			cur_next_q <= stk_next_q[p_idx];
			cur_disc_q <= stk_disc_q[p_idx];
			cur_low_q  <= (cur_low_q < stk_low_q[p_idx]) ? cur_low_q : stk_low_q[p_idx];
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_point || cmd.emit_end) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_point) begin
			out_kind_q   <= KIND_POINT;
			out_vertex_q <= VertexWidth'(emit_idx_q);
			out_last_q   <= 1'b0;
		end else if (cmd.emit_end) begin
			out_kind_q   <= KIND_END;
			out_vertex_q <= '0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_vertex = out_vertex_q;
	assign out_last   = out_last_q;

endmodule

@@ design/articulation_point_finder_unit.sv @@
// Articulation point finder. Add and clear complete without leaving the idle state.
// A search for n vertices in use scans each adjacency bit of each
// visited vertex in the walk loop, with root scan and stack pops, then
// steps through the report slots; then an end marker.
// Sequential: the next request is taken once the end marker is issued; result stalls delay it.
// Reset clears the matrix, the walk control and sets the vertex count to 16.
module articulation_point_finder_unit #(
	parameter int MAX_VERTICES = apf_pkg::DefMaxVertices
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [apf_pkg::CountWidth-1:0] cfg_wdata,
	apf_req_if.sink                        request,
	apf_rsp_if.source                      result
);
	import apf_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	apf_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (request.valid),
		.in_command (request.command),
		.in_ready   (request.ready),
		.status     (status),
		.cmd        (cmd)
	);

	apf_dp #(
		.MAX_VERTICES(MAX_VERTICES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.vertex_a   (request.vertex_a),
		.vertex_b   (request.vertex_b),
		.cmd        (cmd),
		.status     (status),
		.out_valid  (result.valid),
		.out_ready  (result.ready),
		.out_kind   (result.kind),
		.out_vertex (result.vertex),
		.out_last   (result.last)
	);

endmodule

@@ verif/apf_scoreboard.sv @@
`timescale 1ns / 1ps
// Scoreboard for the articulation point finder: graph mirror, cut vertex
// search and expected result queue. Depends on apf_pkg.
class apf_scoreboard;
	bit [15:0] graph_rows[16];
	bit [4:0]  vertex_limit;
	bit [5:0]  expected_cuts[$];
	int        mismatches;
	int        checked;

	function new();
		foreach (graph_rows[i]) graph_rows[i] = '0;
		vertex_limit = apf_pkg::CountReset;
		mismatches = 0;
		checked = 0;
	endfunction

	function void set_count(bit [4:0] value);
		vertex_limit = value;
	endfunction

	// Compute cut vertices by an iterative depth-first walk
	function bit [15:0] find_cuts();
		int n;
		int sp;
		int stamp;
		int kids;
		int v;
		int i;
		int p;
		int disc[16];
		int low[16];
		int stk_v[16];
		int stk_n[16];
		bit [15:0] cuts;
		n = (vertex_limit > 16) ? 16 : vertex_limit;
		cuts = '0;
		stamp = 0;
		sp = 0;
		foreach (disc[k]) begin
			disc[k] = 0;
			low[k] = 0;
		end
		for (int r = 0; r < n; r++) begin
			if (disc[r] != 0)
				continue;
			kids = 0;
			stamp++;
			disc[r] = stamp;
			low[r] = stamp;
			stk_v[sp] = r;
			stk_n[sp] = 0;
			sp++;
			while (sp > 0) begin
				v = stk_v[sp-1];
				if (stk_n[sp-1] < n) begin
					i = stk_n[sp-1];
					stk_n[sp-1]++;
					if (graph_rows[v][i]) begin
						if (disc[i] == 0) begin
							if (v == r)
								kids++;
							if (sp < 16) begin
								stamp++;
								disc[i] = stamp;
								low[i] = stamp;
								stk_v[sp] = i;
								stk_n[sp] = 0;
								sp++;
							end
						end else if (disc[i] < low[v]) begin
							low[v] = disc[i];
						end
					end
				end else begin
					sp--;
					if (sp > 0) begin
						p = stk_v[sp-1];
						if (low[v] < low[p])
							low[p] = low[v];
						if (p != r && low[v] >= disc[p])
							cuts[p] = 1'b1;
					end
				end
			end
			if (kids > 1)
				cuts[r] = 1'b1;
		end
		return cuts;
	endfunction

	// Note an accepted request transfer
	function void note_request(bit [1:0] command, bit [3:0] va, bit [3:0] vb);
		bit [15:0] cuts;
		if (command == apf_pkg::CMD_ADD) begin
			graph_rows[va][vb] = 1'b1;
			graph_rows[vb][va] = 1'b1;
		end else if (command == apf_pkg::CMD_CLEAR) begin
			foreach (graph_rows[i]) graph_rows[i] = '0;
		end else if (command == apf_pkg::CMD_SEARCH) begin
			cuts = find_cuts();
			for (int v = 0; v < 16; v++)
				if (cuts[v])
					expected_cuts.push_back({apf_pkg::KIND_POINT, v[3:0], 1'b0});
			expected_cuts.push_back({apf_pkg::KIND_END, 4'd0, 1'b1});
		end
	endfunction

	// Compare a result transfer with the oldest expectation
	function void check_result(bit kind, bit [3:0] vertex, bit last);
		bit [5:0] want;
		checked++;
		if (expected_cuts.size() == 0) begin
			$error("unexpected result kind=%0d vertex=%0d last=%0d", kind, vertex, last);
			mismatches++;
			return;
		end
		want = expected_cuts.pop_front();
		if (want[5] != kind) begin
			$error("kind: expected %0d, got %0d", want[5], kind);
			mismatches++;
		end
		if (want[4:1] != vertex) begin
			$error("vertex: expected %0d, got %0d", want[4:1], vertex);
			mismatches++;
		end
		if (want[0] != last) begin
			$error("last: expected %0d, got %0d", want[0], last);
			mismatches++;
		end
	endfunction
endclass

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// Top level testbench for articulation_point_finder_unit: directed and random
// graphs with vertex count changes. Depends on apf_pkg, apf_if, apf_scoreboard.
module tb_top;
	import apf_pkg::*;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [4:0] cfg_wdata = '0;
	bit         calm = 1'b0;
	int         searches = 0;
	int         items = 0;

	apf_req_if request ();
	apf_rsp_if result ();

	apf_scoreboard cut_board = new();

	articulation_point_finder_unit DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.request(request), .result(result)
	);

	always #1 clk = ~clk;

	initial begin
		request.valid = 1'b0;
		request.command = '0;
		request.vertex_a = '0;
		request.vertex_b = '0;
		result.ready = 1'b0;
	end

	// Sink side: random stalls, check each result transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready)
				cut_board.check_result(result.kind, result.vertex, result.last);
			result.ready <= calm || ($urandom_range(99) >= 17);
		end
	end

	// Send one request, idling at random before it
	task automatic send(bit [1:0] command, bit [3:0] va, bit [3:0] vb);
		while (!calm && $urandom_range(99) < 17) begin
			request.valid <= 1'b0;
			@(posedge clk);
		end
		request.valid <= 1'b1;
		request.command <= command;
		request.vertex_a <= va;
		request.vertex_b <= vb;
		@(posedge clk);
		while (!request.ready)
			@(posedge clk);
		cut_board.note_request(command, va, vb);
		items++;
		if (command == CMD_SEARCH)
			searches++;
	endtask

	// Wait for all results, then program a new vertex count
	task automatic set_count(bit [4:0] value);
		request.valid <= 1'b0;
		@(posedge clk);
		while (cut_board.expected_cuts.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		cut_board.set_count(value);
	endtask

	// Random graph: mostly edges within the active vertices, then a search and a clear
	task automatic random_graph(int edges, int span);
		bit [1:0] cmd;
		for (int k = 0; k < edges; k++) begin
			if ($urandom_range(19) == 0) begin
				cmd = 2'($urandom_range(3));
				send(cmd, 4'($urandom), 4'($urandom));
			end else begin
				send(CMD_ADD, 4'($urandom_range(span - 1)), 4'($urandom_range(span - 1)));
			end
		end
		send(CMD_SEARCH, 4'($urandom), 4'($urandom));
		send(CMD_CLEAR, 4'($urandom), 4'($urandom));
	endtask

	initial begin
		int span;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty graph, path, star, cycle, loops, extremes, ignored command
		send(CMD_SEARCH, 4'd15, 4'd15);
		send(CMD_ADD, 4'd0, 4'd1);
		send(CMD_ADD, 4'd1, 4'd2);
		send(CMD_ADD, 4'd2, 4'd2);
		send(CMD_ADD, 4'd1, 4'd0);
		send(CMD_ADD, 4'd15, 4'd14);
		send(CMD_ADD, 4'd14, 4'd13);
		send(CMD_SEARCH, 4'd0, 4'd0);
		send(2'd3, 4'd15, 4'd15);
		send(CMD_CLEAR, 4'd0, 4'd0);
		for (int k = 1; k < 5; k++)
			send(CMD_ADD, 4'd5, k[3:0]);
		send(CMD_ADD, 4'd3, 4'd4);
		send(CMD_SEARCH, 4'd0, 4'd0);
		set_count(5'd0);
		send(CMD_SEARCH, 4'd0, 4'd0);
		set_count(5'd3);
		send(CMD_ADD, 4'd0, 4'd7);
		send(CMD_SEARCH, 4'd0, 4'd0);
		set_count(5'd31);
		send(CMD_SEARCH, 4'd0, 4'd0);
		set_count(5'd1);
		send(CMD_SEARCH, 4'd0, 4'd0);
		send(CMD_CLEAR, 4'd0, 4'd0);

		// Random: sparse graphs over various counts, one calm stretch
		for (int g = 0; items < 200; g++) begin
			span = (g % 4 == 0) ? 16 : $urandom_range(2, 16);
			set_count((g % 5 == 0) ? 5'd16 : span[4:0]);
			calm = (g >= 3 && g < 6);
			random_graph($urandom_range(2, 14), span);
		end
		calm = 1'b0;
		request.valid <= 1'b0;
		@(posedge clk);
		while (cut_board.expected_cuts.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
		$display("Covered %0d searches over random graphs and vertex counts 0 to 31,",
			searches);
		$display("with %0d result transfers checked under random stalls.",
			cut_board.checked);
		if (cut_board.mismatches == 0 && cut_board.expected_cuts.size() == 0)
			$display("[articulation_point_finder_unit] OK");
		else
			$display("[articulation_point_finder_unit] ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("[articulation_point_finder_unit] ERROR");
		$finish;
	end
endmodule
